>>> src/irdc_pkg.sv
package irdc_pkg;

  localparam int RESULT_CAP = 31;

  localparam logic [6:0] ASCII_DIGIT_BASE  = 7'd48;
  localparam logic [6:0] ASCII_LETTER_BASE = 7'd55;
  localparam logic [3:0] DEC_RADIX         = 4'd10;

  typedef enum logic [1:0] {
    FUNC_BIN = 2'd0,
    FUNC_OCT = 2'd1,
    FUNC_HEX = 2'd2,
    FUNC_DEC = 2'd3
  } func_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DABBLE = 6'b000010,
    ST_SPLIT  = 6'b000100,
    ST_PREP   = 6'b001000,
    ST_SHOW   = 6'b010000,
    ST_EMPTY  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;     // capture a new item
    logic dabble;   // one double-dabble step
    logic split;    // peel one digit into the store
    logic prep;     // point the read port at the top digit
    logic advance;  // result transfer, step to next digit
    logic empty;    // present the empty result
  } cmd_t;

  typedef struct packed {
    logic in_positive;
    logic in_decimal;
    logic dabble_done;
    logic split_done;
    logic at_last;
  } status_t;

  function automatic logic [6:0] ascii_of(input logic [3:0] d);
    if (d < DEC_RADIX) begin
      return ASCII_DIGIT_BASE + 7'(d);
    end
    return ASCII_LETTER_BASE + 7'(d);
  endfunction

endpackage

>>> src/irdc_ifs.sv
interface irdc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface irdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_value;
  logic [6:0] char_code;
  logic       is_empty;
  logic       last;

  modport source (output valid, output digit_value, output char_code, output is_empty,
                  output last, input ready);
  modport sink   (input valid, input digit_value, input char_code, input is_empty,
                  input last, output ready);
endinterface

>>> src/irdc_ctrl.sv
module irdc_ctrl
  import irdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.in_positive) begin
            state_next = ST_EMPTY;
          end else if (status.in_decimal) begin
            state_next = ST_DABBLE;
          end else begin
            state_next = ST_SPLIT;
          end
        end
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
        if (status.dabble_done) begin
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (status.split_done) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (status.at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        out_valid = 1'b1;
        cmd.empty = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/irdc_dp.sv
module irdc_dp
  import irdc_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 31
) (
  input  logic               clk,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  input  cmd_t               cmd,
  output status_t            status,
  output logic [3:0]         digit_value,
  output logic [6:0]         char_code,
  output logic               is_empty,
  output logic               last
);

  localparam int LIMIT      = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
  localparam int LOAD_BITS  = (VALUE_BITS < 31) ? VALUE_BITS : 31;
  // decimal digits needed for LOAD_BITS bits (log10(2) ~ 0.30103)
  localparam int DEC_DIGITS = (LOAD_BITS * 30103) / 100000 + 1;
  localparam int SPAN       = (LOAD_BITS > 4 * DEC_DIGITS) ? LOAD_BITS : 4 * DEC_DIGITS;
  localparam int NIB        = (SPAN + 3) / 4;
  localparam int W          = 4 * NIB;
  localparam int CNT_W      = $clog2(LIMIT + 1);
  localparam int IDX_W      = $clog2(LIMIT);
  localparam int STEP_W     = $clog2(LOAD_BITS);

  logic [1:0]           func_q;
  logic [LOAD_BITS-1:0] bin;
  logic [W-1:0]         work;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [3:0]           rd_data;
  logic [3:0]           store [LIMIT];

  logic [LOAD_BITS-1:0] loaded;
  logic [W-1:0]         adj;
  logic [W-1:0]         work_sh;
  logic [3:0]           digit;
  logic [CNT_W-1:0]     cnt_m1;

  assign loaded = value[LOAD_BITS-1:0];

  assign status.in_positive = !value[31] && (loaded != '0);
  assign status.in_decimal  = (func == FUNC_DEC);
  assign status.dabble_done = (step == STEP_W'(LOAD_BITS - 1));
  assign status.split_done  = (work_sh == '0) || (count == CNT_W'(LIMIT - 1));
  assign status.at_last     = (idx == '0);

  // add-3 correction on every BCD nibble
  always_comb begin
    for (int n = 0; n < NIB; n++) begin
      adj[4*n +: 4] = (work[4*n +: 4] >= 4'd5) ? work[4*n +: 4] + 4'd3 : work[4*n +: 4];
    end
  end

  // BCD nibbles split exactly like hex digits
  always_comb begin
    case (func_q)
      FUNC_BIN: begin
        work_sh = work >> 1;
        digit   = {3'b000, work[0]};
      end
      FUNC_OCT: begin
        work_sh = work >> 3;
        digit   = {1'b0, work[2:0]};
      end
      default: begin
        work_sh = work >> 4;
        digit   = work[3:0];
      end
    endcase
  end

  assign cnt_m1 = count - CNT_W'(1);

  always_comb begin
    idx_next = idx;
    if (cmd.prep) begin
      idx_next = cnt_m1[IDX_W-1:0];
    end else if (cmd.advance) begin
      idx_next = idx - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      step   <= '0;
      count  <= '0;
      bin    <= loaded;
      work   <= (func == FUNC_DEC) ? '0 : W'(loaded);
    end else if (cmd.dabble) begin
      work <= {adj[W-2:0], bin[LOAD_BITS-1]};
      bin  <= {bin[LOAD_BITS-2:0], 1'b0};
      step <= step + STEP_W'(1);
    end else if (cmd.split) begin
      work  <= work_sh;
      count <= count + CNT_W'(1);
    end
    idx     <= idx_next;
    rd_data <= store[idx_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      store[count[IDX_W-1:0]] <= digit;
    end
  end

  assign is_empty    = cmd.empty;
  assign last        = cmd.empty || status.at_last;
  assign digit_value = cmd.empty ? 4'd0 : rd_data;
  assign char_code   = cmd.empty ? 7'd0 : ascii_of(rd_data);

endmodule

>>> src/integer_radix_digit_converter.sv
// Integer to radix digit converter.
// Input channel (item): func selects the base (binary, octal, hex, decimal
// BCD) and value is a signed 32-bit integer. Output channel (result): one
// transfer per digit, most significant first, with the digit value, its
// ASCII character and last on the final digit. A value of zero or below
// gives a single result with is_empty and last set.
// Timing: item accepted only when the block is idle. Binary, octal and hex
// peel the digits one by one into a small store; decimal first runs one
// double-dabble step per value bit (VALUE_BITS, capped at 31), then peels
// the BCD digits. A setup step follows, then digits stream at one per
// cycle while the receiver holds ready high. An empty result appears the
// cycle after the transfer in.
// Reset (synchronous, rst high) returns the controller to idle; any item
// in flight is dropped. When the receiver stalls, the current result holds
// and digit output resumes when ready returns.
module integer_radix_digit_converter
  import irdc_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 31
) (
  input logic        clk,
  input logic        rst,
  irdc_in_if.sink    item,
  irdc_out_if.source result
);

  cmd_t    cmd;
  status_t status;

  irdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  irdc_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .func        (item.func),
    .value       (item.value),
    .cmd         (cmd),
    .status      (status),
    .digit_value (result.digit_value),
    .char_code   (result.char_code),
    .is_empty    (result.is_empty),
    .last        (result.last)
  );

endmodule

>>> src/irdc_checker.sv
module irdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_digit,
  input logic [6:0]  out_char,
  input logic        out_empty,
  input logic        out_last
);

  // no new item while a result is pending
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last)
    else $error("empty result not marked last");

  a_char_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_empty |->
      ((out_digit < 4'd10) && (out_char == 7'd48 + 7'(out_digit))) ||
      ((out_digit >= 4'd10) && (out_char == 7'd55 + 7'(out_digit))))
    else $error("character does not match digit");

  a_negative_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_value[31] |=> out_valid && out_empty)
    else $error("negative value did not give an empty result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind integer_radix_digit_converter irdc_checker u_irdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_value  (item.value),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_digit (result.digit_value),
  .out_char  (result.char_code),
  .out_empty (result.is_empty),
  .out_last  (result.last)
);

>>> dv/tb_integer_radix_digit_converter.sv
`timescale 1ns / 1ps
module tb_integer_radix_digit_converter
  import irdc_pkg::*;
();

  typedef struct {
    func_t              func;
    logic signed [31:0] value;
    bit                 drain_first;  // hold off until all digits are back
  } conv_req_t;

  typedef struct {
    logic [3:0] digit_value;
    logic [6:0] char_code;
    logic       is_empty;
    logic       last;
  } digit_rec_t;

  localparam int CALM_ITEMS  = 40;
  localparam int TAIL_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  irdc_in_if  item_if ();
  irdc_out_if result_if ();

  integer_radix_digit_converter u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  conv_req_t  req_q[$];
  digit_rec_t expected_digits[$];
  int         fail_count = 0;
  bit         req_taken  = 1'b0;
  bit         req_held   = 1'b0;
  int         send_gap   = 0;
  int         stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [6:0] char_of(input logic [3:0] d);
    if (d < 4'd10) begin
      return 7'd48 + 7'(d);
    end
    return 7'd55 + 7'(d);
  endfunction

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
    fail_count++;
  endtask

  task automatic predict_digits(input func_t f, input logic signed [31:0] v);
    logic [3:0]  digits [0:31];
    logic [31:0] rest;
    logic [31:0] radix;
    digit_rec_t  rec;
    int          n;
    int          i;
    case (f)
      FUNC_BIN: radix = 32'd2;
      FUNC_OCT: radix = 32'd8;
      FUNC_HEX: radix = 32'd16;
      default:  radix = 32'd10;
    endcase
    rest = v[31] ? 32'd0 : {1'b0, v[30:0]};
    if (rest == 32'd0) begin
      rec = '{4'd0, 7'd0, 1'b1, 1'b1};
      expected_digits.push_back(rec);
      return;
    end
    n = 0;
    while (rest != 32'd0 && n < 31) begin
      digits[n] = 4'(rest % radix);
      rest      = rest / radix;
      n++;
    end
    for (i = n - 1; i >= 0; i--) begin
      rec.digit_value = digits[i];
      rec.char_code   = char_of(digits[i]);
      rec.is_empty    = 1'b0;
      rec.last        = (i == 0);
      expected_digits.push_back(rec);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : mon
    digit_rec_t exp_rec;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected result, digit_value", -1, result_if.digit_value);
        end else begin
          exp_rec = expected_digits.pop_front();
          if (result_if.digit_value !== exp_rec.digit_value)
            report_mismatch("digit_value", exp_rec.digit_value, result_if.digit_value);
          if (result_if.char_code !== exp_rec.char_code)
            report_mismatch("char_code", exp_rec.char_code, result_if.char_code);
          if (result_if.is_empty !== exp_rec.is_empty)
            report_mismatch("is_empty", exp_rec.is_empty, result_if.is_empty);
          if (result_if.last !== exp_rec.last)
            report_mismatch("last", exp_rec.last, result_if.last);
        end
      end
      if (item_if.valid && item_if.ready) begin
        predict_digits(func_t'(item_if.func), item_if.value);
        req_taken = 1'b1;
      end
    end
  end

  // input driver, falling edge
  always @(negedge clk) begin : drv
    conv_req_t cur;
    if (!rst) begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_held  = 1'b0;
        if (req_q.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 17);
      end
      if (!req_held) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0 &&
                     (!req_q[0].drain_first || expected_digits.size() == 0)) begin
          cur = req_q.pop_front();
          item_if.func  <= cur.func;
          item_if.value <= cur.value;
          req_held = 1'b1;
        end
      end
      item_if.valid <= req_held;
    end
  end

  // result receiver, falling edge
  always @(negedge clk) begin : rcv
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if (req_q.size() >= CALM_ITEMS && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 17);
    end
  end

  task automatic add_req(input func_t f, input logic [31:0] v, input bit drain);
    conv_req_t r;
    r.func        = f;
    r.value       = v;
    r.drain_first = drain;
    req_q.push_back(r);
  endtask

  initial begin : stim
    int          kind;
    int          len;
    func_t       f;
    logic [31:0] v;
    logic [31:0] p;
    item_if.valid   = 1'b0;
    item_if.func    = FUNC_BIN;
    item_if.value   = '0;
    result_if.ready = 1'b0;

    // zero, negative, largest positive and one in every base
    for (int k = 0; k < 4; k++) begin
      f = func_t'(k);
      add_req(f, 32'd0, 1'b0);
      add_req(f, 32'hFFFF_FFFF, 1'b0);
      add_req(f, 32'h7FFF_FFFF, 1'b0);
      add_req(f, 32'd1, 1'b0);
    end
    add_req(FUNC_BIN, 32'h8000_0000, 1'b0);
    add_req(FUNC_DEC, 32'd9, 1'b0);
    add_req(FUNC_DEC, 32'd10, 1'b0);
    add_req(FUNC_HEX, 32'd15, 1'b0);
    add_req(FUNC_HEX, 32'd16, 1'b0);
    add_req(FUNC_OCT, 32'd7, 1'b0);
    add_req(FUNC_OCT, 32'd8, 1'b0);
    add_req(FUNC_HEX, 32'h00AB_CDEF, 1'b0);
    add_req(FUNC_DEC, 32'd1000000000, 1'b0);

    for (int n = 0; n < 425; n++) begin
      f    = func_t'($urandom_range(0, 3));
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 31);
        v   = ($urandom & ((32'd1 << len) - 32'd1)) | (32'd1 << (len - 1));
      end else if (kind < 60) begin
        v = $urandom_range(0, 20);
      end else if (kind < 75) begin
        v = $urandom;
      end else if (kind < 85) begin
        v = $urandom | 32'h8000_0000;
      end else begin
        // powers of ten and their predecessors exercise BCD carries
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v = p - 32'($urandom_range(0, 1));
      end
      add_req(f, v, (n % 150) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || req_held || expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
